/* rtl/core/urpw_pkg.sv */
// Package for the response pattern watcher: slot type, register indexes,
// mode, status and opcode codes, and the fixed reply texts.
// No dependencies.
package urpw_pkg;

  localparam int unsigned WINDOW     = 10;
  localparam int unsigned NPAT       = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OK_LEN     = 6;

  // Texts stored first character in the top byte.
  localparam logic [WINDOW*8-1:0] CONN_TEXT = "Connection";
  localparam logic [OK_LEN*8-1:0] OK_TEXT   = "200 OK";

  localparam int unsigned PAT_SA = 0;
  localparam int unsigned PAT_SB = 1;
  localparam int unsigned PAT_EA = 2;
  localparam int unsigned PAT_EB = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_B   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTHS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LISTEN    = 3'd6;

  localparam logic [2:0] MODE_SA           = 3'd0;
  localparam logic [2:0] MODE_SA_EA        = 3'd1;
  localparam logic [2:0] MODE_SA_EAB       = 3'd2;
  localparam logic [2:0] MODE_SAB_EA       = 3'd3;
  localparam logic [2:0] MODE_SAB_EAB_CONN = 3'd4;

  localparam logic [1:0] STATUS_PENDING = 2'd0;
  localparam logic [1:0] STATUS_SUCCESS = 2'd1;
  localparam logic [1:0] STATUS_ERROR   = 2'd2;

  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } urpw_slot_t;

endpackage

/* rtl/core/urpw_cell.sv */
// One window cell of the response pattern watcher: holds one history byte,
// passes it to the next cell and compares the incoming byte with pattern text.
// Depends on urpw_pkg.
module urpw_cell
  import urpw_pkg::*;
#(
  parameter int unsigned CELL_IDX      = 0,
  parameter int unsigned PATTERN_CHARS = 8
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       shift_en_i,
  input  logic                                       flush_i,
  input  urpw_slot_t                                 slot_i,
  input  logic [NPAT-1:0][PATTERN_CHARS-1:0][7:0]    pattern_i,
  output urpw_slot_t                                 slot_o,
  output logic [NPAT-1:0][PATTERN_CHARS-1:0]         pat_eq_o,
  output logic                                       conn_eq_o,
  output logic                                       ok_eq_o
);

  localparam bit IS_HEAD = (CELL_IDX == 0);

  urpw_slot_t view;
  logic       valid_q;
  logic [7:0] data_q;

  always_comb begin
    view       = slot_i;
    view.valid = slot_i.valid & (IS_HEAD | ~flush_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_en_i) begin
      valid_q <= view.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      data_q <= view.data;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.data  = data_q;

  for (genvar p = 0; p < NPAT; p++) begin : g_pat
    for (genvar l = 1; l <= PATTERN_CHARS; l++) begin : g_len
      if (CELL_IDX >= l) begin : g_out
        assign pat_eq_o[p][l-1] = 1'b1;
      end else begin : g_cmp
        assign pat_eq_o[p][l-1] = view.valid && (view.data == pattern_i[p][l-1-CELL_IDX]);
      end
    end
  end

  assign conn_eq_o = view.valid && (view.data == CONN_TEXT[CELL_IDX*8 +: 8]);

  if (CELL_IDX < OK_LEN) begin : g_ok
    assign ok_eq_o = view.valid && (view.data == OK_TEXT[CELL_IDX*8 +: 8]);
  end else begin : g_no_ok
    assign ok_eq_o = 1'b1;
  end

endmodule

/* rtl/core/uart_response_pattern_watcher.sv */
// Response pattern watcher: watches received modem bytes for reply patterns.
// Top level; builds on urpw_pkg and a row of urpw_cell window cells.
//
// Usage:
//   Requests enter on in_valid_i/in_stall_o with opcode_i and rx_byte_i.
//   A request is taken at a clock edge with in_valid_i high and in_stall_o low.
//   Opcode "command" arms a history clear and drops any latched decision.
//   Opcode "byte" shifts rx_byte_i into a ten-cell window when listening is on.
//   Each request yields one result on out_valid_o/out_stall_i:
//   status_o, decided_now_o and history_wrapped_o.
//   Throughput is one request per cycle while in_stall_o is low; every cell
//   compares the byte entering it with the pattern texts in the same cycle.
//   The result sits in an output register; a new request is taken while it
//   is being taken, so stalls only hold the input when the register is full.
//   Configuration is written on cfg_we_i/cfg_index_i/cfg_data_i; the user
//   must do so only while idle, and the block does not enforce it. Reset
//   clears the window, byte count, decision and configuration registers.
module uart_response_pattern_watcher
  import urpw_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 300,
  parameter int unsigned PATTERN_CHARS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic                  decided_now_o,
  output logic                  history_wrapped_o
);

  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned EW = $clog2(PATTERN_CHARS + 1);

  logic [2:0]                              mode_q;
  logic [NPAT-1:0][PATTERN_CHARS-1:0][7:0] pattern_q;
  logic [NPAT-1:0][3:0]                    lengths_q;
  logic                                    listen_q;

  logic [CW-1:0] count_q, count_d;
  logic          decided_q, decided_d;
  logic [1:0]    verdict_q, verdict_d;
  logic          ok_seen_q, ok_seen_d;
  logic          zero_seen_q, zero_seen_d;
  logic          clear_pending_q, clear_pending_d;

  logic       out_valid_q;
  logic [1:0] status_q, status_d;
  logic       now_q, now_d;
  logic       wrap_q, wrap_d;

  logic accept, byte_step, full, flush, wrapped, hidden, ok_prev;

  urpw_slot_t [WINDOW-1:0]                       slot_in, slot_out;
  logic [WINDOW-1:0][NPAT-1:0][PATTERN_CHARS-1:0] pat_eq;
  logic [WINDOW-1:0]                             conn_eq, ok_eq;
  logic [NPAT-1:0][PATTERN_CHARS-1:0]            and_all;
  logic [NPAT-1:0][EW-1:0]                       eff;
  logic [NPAT-1:0]                               hit;
  logic conn_all, ok_all, succ, err;

  function automatic logic [EW-1:0] eff_len(input logic [3:0] len,
                                            input logic [PATTERN_CHARS-1:0][7:0] chars);
    int unsigned lim;
    logic        run;
    logic [EW-1:0] n;
    lim = (int'(len) > PATTERN_CHARS) ? PATTERN_CHARS : int'(len);
    run = 1'b1;
    n   = '0;
    for (int unsigned i = 0; i < PATTERN_CHARS; i++) begin
      if (run && (i < lim) && (chars[i] != 8'd0)) begin
        n = n + EW'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SA;
      pattern_q <= '0;
      lengths_q <= '0;
      listen_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE:      mode_q            <= cfg_data_i[2:0];
        REG_SUCCESS_A: pattern_q[PAT_SA] <= cfg_data_i[PATTERN_CHARS*8-1:0];
        REG_SUCCESS_B: pattern_q[PAT_SB] <= cfg_data_i[PATTERN_CHARS*8-1:0];
        REG_ERROR_A:   pattern_q[PAT_EA] <= cfg_data_i[PATTERN_CHARS*8-1:0];
        REG_ERROR_B:   pattern_q[PAT_EB] <= cfg_data_i[PATTERN_CHARS*8-1:0];
        REG_LENGTHS:   lengths_q         <= cfg_data_i[NPAT*4-1:0];
        REG_LISTEN:    listen_q          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign byte_step  = accept & (opcode_i == OP_RX_BYTE) & listen_q;

  assign full    = (count_q >= CW'(HISTORY_DEPTH));
  assign flush   = clear_pending_q | full;
  assign wrapped = ~clear_pending_q & full;
  assign hidden  = ~flush & zero_seen_q;
  assign ok_prev = ~flush & ok_seen_q;

  for (genvar c = 0; c < WINDOW; c++) begin : g_cell
    if (c == 0) begin : g_head
      assign slot_in[c].valid = 1'b1;
      assign slot_in[c].data  = rx_byte_i;
    end else begin : g_link
      assign slot_in[c] = slot_out[c-1];
    end
    urpw_cell #(
      .CELL_IDX      (c),
      .PATTERN_CHARS (PATTERN_CHARS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (byte_step),
      .flush_i    (flush),
      .slot_i     (slot_in[c]),
      .pattern_i  (pattern_q),
      .slot_o     (slot_out[c]),
      .pat_eq_o   (pat_eq[c]),
      .conn_eq_o  (conn_eq[c]),
      .ok_eq_o    (ok_eq[c])
    );
  end

  always_comb begin
    and_all = '1;
    for (int unsigned c = 0; c < WINDOW; c++) begin
      and_all = and_all & pat_eq[c];
    end
    conn_all = &conn_eq;
    ok_all   = &ok_eq;
    for (int unsigned p = 0; p < NPAT; p++) begin
      eff[p] = eff_len(lengths_q[p], pattern_q[p]);
      hit[p] = 1'b0;
      for (int unsigned l = 1; l <= PATTERN_CHARS; l++) begin
        if (eff[p] == EW'(l)) begin
          hit[p] = ~hidden & and_all[p][l-1];
        end
      end
      if (eff[p] == '0) begin
        hit[p] = 1'b1;
      end
    end
  end

  always_comb begin
    succ = 1'b0;
    err  = 1'b0;
    unique case (mode_q)
      MODE_SA: begin
        succ = hit[PAT_SA];
      end
      MODE_SA_EA: begin
        succ = hit[PAT_SA];
        err  = hit[PAT_EA];
      end
      MODE_SA_EAB: begin
        succ = hit[PAT_SA];
        err  = hit[PAT_EA] | hit[PAT_EB];
      end
      MODE_SAB_EA: begin
        succ = hit[PAT_SA] | hit[PAT_SB];
        err  = hit[PAT_EA];
      end
      MODE_SAB_EAB_CONN: begin
        succ = hit[PAT_SA] | hit[PAT_SB];
        err  = hit[PAT_EA] | hit[PAT_EB] | (~hidden & ~ok_prev & conn_all);
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d         = count_q;
    decided_d       = decided_q;
    verdict_d       = verdict_q;
    ok_seen_d       = ok_seen_q;
    zero_seen_d     = zero_seen_q;
    clear_pending_d = clear_pending_q;
    status_d        = verdict_q;
    now_d           = 1'b0;
    wrap_d          = 1'b0;
    if (accept && (opcode_i == OP_COMMAND)) begin
      clear_pending_d = 1'b1;
      decided_d       = 1'b0;
      verdict_d       = STATUS_PENDING;
      status_d        = STATUS_PENDING;
    end else if (byte_step) begin
      clear_pending_d = 1'b0;
      count_d         = (flush ? '0 : count_q) + CW'(1);
      zero_seen_d     = hidden | (rx_byte_i == 8'd0);
      ok_seen_d       = ok_prev | (~hidden & ok_all);
      wrap_d          = wrapped;
      if (!decided_q && succ) begin
        verdict_d = STATUS_SUCCESS;
        decided_d = 1'b1;
        now_d     = 1'b1;
      end else if (!decided_q && err) begin
        verdict_d = STATUS_ERROR;
        decided_d = 1'b1;
        now_d     = 1'b1;
      end
      status_d = verdict_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      decided_q       <= 1'b0;
      verdict_q       <= STATUS_PENDING;
      ok_seen_q       <= 1'b0;
      zero_seen_q     <= 1'b0;
      clear_pending_q <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      count_q         <= count_d;
      decided_q       <= decided_d;
      verdict_q       <= verdict_d;
      ok_seen_q       <= ok_seen_d;
      zero_seen_q     <= zero_seen_d;
      clear_pending_q <= clear_pending_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      now_q    <= now_d;
      wrap_q   <= wrap_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign decided_now_o     = now_q;
  assign history_wrapped_o = wrap_q;

  a_now_has_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decided_now_o |-> status_o != STATUS_PENDING)
    else $error("decision reported without a verdict");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(HISTORY_DEPTH))
    else $error("byte count above history depth");

  a_wrap_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_step && wrapped |=> count_q == CW'(1))
    else $error("history wrap did not restart the count");

  a_undecided_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !decided_q |-> verdict_q == STATUS_PENDING)
    else $error("verdict held without a decision");

endmodule
